// ===== hw/rtl/asf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_pkg
// Shared types and constants of the drop-oldest audio sample FIFO.
// ----------------------------------------------------------------------------
package asf_pkg;

  // Store depth in samples (power of two) and largest block read.
  localparam int DEPTH    = 2048;
  localparam int MAX_READ = 64;

  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 7;
  localparam int FILL_W   = 12;
  localparam int STATUS_W = 3;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_WRITTEN  = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_REJECTED = 3'd2,
    ST_SHORT    = 3'd3,
    ST_DATA     = 3'd4
  } status_t;

  // Item opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_write;
    logic acc_reject;
    logic acc_short;
    logic acc_read;
    logic rd_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_ok;
    logic rd_last;
  } stat_t;

endpackage

// ===== hw/rtl/asf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module asf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/asf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_ctrl
// Controller: decodes accepted items and sequences block reads.
// ----------------------------------------------------------------------------
module asf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_op,
  input  logic           in_is_voice,
  input  asf_pkg::stat_t stat,
  output asf_pkg::cmd_t  cmd,
  output logic           busy
);

  asf_pkg::state_t state_r, state_nxt;
  logic            accept;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a good read streams until its last sample is fetched.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      asf_pkg::S_IDLE: begin
        if (cmd.acc_read) state_nxt = asf_pkg::S_READ;
      end
      asf_pkg::S_READ: begin
        if (stat.rd_last) state_nxt = asf_pkg::S_IDLE;
      end
      default: state_nxt = asf_pkg::S_IDLE;
    endcase
  end

  // Outputs: item decode while idle, fetch steps while reading.
  always_comb begin
    busy           = 1'b0;
    cmd            = '0;
    accept         = 1'b0;
    case (state_r)
      asf_pkg::S_IDLE: begin
        accept         = start;
        cmd.acc_write  = accept && (in_op == asf_pkg::OP_WRITE) && in_is_voice;
        cmd.acc_reject = accept && (in_op == asf_pkg::OP_WRITE) && !in_is_voice;
        cmd.acc_read   = accept && (in_op == asf_pkg::OP_READ) && stat.rd_ok;
        cmd.acc_short  = accept && (in_op == asf_pkg::OP_READ) && !stat.rd_ok;
      end
      asf_pkg::S_READ: begin
        busy        = 1'b1;
        cmd.rd_step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/asf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_dp
// Datapath: sample store, pointers, fill count and result registers.
// ----------------------------------------------------------------------------
module asf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  asf_pkg::cmd_t                       cmd,
  output asf_pkg::stat_t                      stat,
  input  logic signed [asf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic        [asf_pkg::COUNT_W-1:0]  in_read_count,
  output logic                                out_valid,
  output logic        [asf_pkg::STATUS_W-1:0] out_status,
  output logic signed [asf_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_last,
  output logic        [asf_pkg::FILL_W-1:0]   out_fill_level
);

  localparam int ADDR_W  = asf_pkg::ADDR_W;
  localparam int CNT_W   = asf_pkg::CNT_W;
  localparam int COUNT_W = asf_pkg::COUNT_W;

  logic [ADDR_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [COUNT_W-1:0] remain_r, remain_nxt;
  logic               full;
  logic [ADDR_W-1:0]  waddr;
  logic [asf_pkg::SAMPLE_W-1:0] rdata;

  logic                   out_valid_r, out_valid_nxt;
  asf_pkg::status_t       out_status_r, out_status_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [CNT_W-1:0]       out_fill_r, out_fill_nxt;
  logic                   out_sel_r, out_sel_nxt;

  assign full = (held_r == CNT_W'(asf_pkg::DEPTH));

  // When full the new sample lands on the oldest slot, which is dropped.
  assign waddr = full ? oldest_r : (oldest_r + held_r[ADDR_W-1:0]);

  // A read is good when its count is in range and enough samples are held.
  assign stat.rd_ok   = (in_read_count != '0) &&
                        (in_read_count <= COUNT_W'(asf_pkg::MAX_READ)) &&
                        (held_r >= CNT_W'(in_read_count));
  assign stat.rd_last = (remain_r == COUNT_W'(1));

  asf_ram #(
    .WIDTH (asf_pkg::SAMPLE_W),
    .DEPTH (asf_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.acc_write),
    .waddr (waddr),
    .wdata (in_sample_in),
    .re    (cmd.rd_step),
    .raddr (oldest_r),
    .rdata (rdata)
  );

  // Pointer, count and result updates.
  always_comb begin
    oldest_nxt     = oldest_r;
    held_nxt       = held_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_fill_nxt   = out_fill_r;
    out_sel_nxt    = 1'b0;
    if (cmd.acc_write) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (full) begin
        oldest_nxt     = oldest_r + ADDR_W'(1);
        out_status_nxt = asf_pkg::ST_DROPPED;
        out_fill_nxt   = held_r;
      end else begin
        held_nxt       = held_r + CNT_W'(1);
        out_status_nxt = asf_pkg::ST_WRITTEN;
        out_fill_nxt   = held_r + CNT_W'(1);
      end
    end
    if (cmd.acc_reject || cmd.acc_short) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = 1'b1;
      out_fill_nxt   = held_r;
      out_status_nxt = cmd.acc_reject ? asf_pkg::ST_REJECTED : asf_pkg::ST_SHORT;
    end
    if (cmd.acc_read) begin
      remain_nxt = in_read_count;
    end
    // Each fetch step removes one sample; its data appears with the result.
    if (cmd.rd_step) begin
      oldest_nxt     = oldest_r + ADDR_W'(1);
      held_nxt       = held_r - CNT_W'(1);
      remain_nxt     = remain_r - COUNT_W'(1);
      out_valid_nxt  = 1'b1;
      out_status_nxt = asf_pkg::ST_DATA;
      out_last_nxt   = stat.rd_last;
      out_fill_nxt   = held_r - CNT_W'(1);
      out_sel_nxt    = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      held_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
      out_sel_r   <= 1'b0;
    end else begin
      oldest_r    <= oldest_nxt;
      held_r      <= held_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      out_sel_r   <= out_sel_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_sample_out = out_sel_r ? rdata : '0;
  assign out_last       = out_last_r;
  assign out_fill_level = asf_pkg::FILL_W'(out_fill_r);

endmodule

// ===== hw/rtl/audio_sample_fifo_drop_oldest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_sample_fifo_drop_oldest
// FIFO of signed audio samples that drops the oldest sample when full and
// answers block reads oldest first.
// ----------------------------------------------------------------------------
//
// Channel   Handshake             Ports
// input     start & !busy         in_op, in_sample_in, in_is_voice,
//                                 in_frame_end, in_read_count
// result    out_valid (1 cycle)   out_status, out_sample_out, out_last,
//                                 out_fill_level
//
// A write or a rejected or short read gives its result in the cycle after it is
// accepted, and busy stays low, so such items may follow every cycle.
// A good read of N samples holds busy high while it fetches one sample
// a cycle from the store's single read port; each result follows in the cycle
// after its fetch, and the next item can be accepted as the last one shows.
// Reset is synchronous and clears pointers and counts; the store is not
// cleared, since only written samples are ever read. Results cannot be
// stalled.
// ----------------------------------------------------------------------------
module audio_sample_fifo_drop_oldest (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic signed [asf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_is_voice,
  input  logic                                in_frame_end,
  input  logic        [asf_pkg::COUNT_W-1:0]  in_read_count,
  output logic                                out_valid,
  output logic        [asf_pkg::STATUS_W-1:0] out_status,
  output logic signed [asf_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_last,
  output logic        [asf_pkg::FILL_W-1:0]   out_fill_level
);

  asf_pkg::cmd_t  cmd;
  asf_pkg::stat_t stat;
  logic           frame_end_unused;

  // Frame boundaries do not affect storage.
  assign frame_end_unused = in_frame_end;

  asf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_op       (in_op),
    .in_is_voice (in_is_voice),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  asf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_sample_in   (in_sample_in),
    .in_read_count  (in_read_count),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_sample_out (out_sample_out),
    .out_last       (out_last),
    .out_fill_level (out_fill_level)
  );

endmodule

// ===== hw/rtl/asf_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_chk
// Port-level checks on the sample FIFO's result stream.
// ----------------------------------------------------------------------------
module asf_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                in_op,
  input logic                                out_valid,
  input logic        [asf_pkg::STATUS_W-1:0] out_status,
  input logic signed [asf_pkg::SAMPLE_W-1:0] out_sample_out,
  input logic                                out_last
);

  // A block read streams without gaps until its last sample.
  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_status == asf_pkg::ST_DATA))
    else $error("block read stream broke before its last item");

  // Anything but read data is a single, final result.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != asf_pkg::ST_DATA) |-> out_last)
    else $error("non-data result not marked last");

  // Only read data carries a sample.
  a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != asf_pkg::ST_DATA) |-> (out_sample_out == '0))
    else $error("non-data result carries a sample");

  // An accepted write answers in the next cycle with one final result.
  a_write_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op == asf_pkg::OP_WRITE) |=>
      out_valid && out_last && (out_status != asf_pkg::ST_DATA))
    else $error("write item not answered in the next cycle");

  // Every busy cycle is followed by a read data result.
  a_busy_streams: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && (out_status == asf_pkg::ST_DATA))
    else $error("busy without a data result following");

endmodule

bind audio_sample_fifo_drop_oldest asf_chk u_asf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_op          (in_op),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_sample_out (out_sample_out),
  .out_last       (out_last)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the drop-oldest audio sample FIFO. Items go in on
// the start/busy handshake. A shadow FIFO predicts every result, and each
// strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_WAIT  = 8;

  localparam int DEPTH    = asf_pkg::DEPTH;
  localparam int MAX_READ = asf_pkg::MAX_READ;
  localparam int ADDR_W   = asf_pkg::ADDR_W;
  localparam int SAMPLE_W = asf_pkg::SAMPLE_W;
  localparam int COUNT_W  = asf_pkg::COUNT_W;
  localparam int FILL_W   = asf_pkg::FILL_W;
  localparam int STATUS_W = asf_pkg::STATUS_W;

  // One predicted result of the FIFO.
  typedef struct packed {
    asf_pkg::status_t    status;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic [FILL_W-1:0]   fill;
  } fifo_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_op;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       in_is_voice;
  logic                       in_frame_end;
  logic        [COUNT_W-1:0]  in_read_count;
  logic                       out_valid;
  logic        [STATUS_W-1:0] out_status;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_last;
  logic        [FILL_W-1:0]   out_fill_level;

  // Shadow copy of the FIFO contents and pointers.
  logic [SAMPLE_W-1:0] shadow_store [0:DEPTH-1];
  int unsigned         shadow_oldest;
  int unsigned         shadow_held;

  fifo_result_t predicted_results [$];
  fifo_result_t due_result;
  int           mismatch_count;
  int           cycle_count;
  int           send_gap_pct;

  audio_sample_fifo_drop_oldest dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_sample_in   (in_sample_in),
    .in_is_voice    (in_is_voice),
    .in_frame_end   (in_frame_end),
    .in_read_count  (in_read_count),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_sample_out (out_sample_out),
    .out_last       (out_last),
    .out_fill_level (out_fill_level)
  );

  // Clock.
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Queue one predicted result, tagged with the fill level after it.
  function automatic void push_result(asf_pkg::status_t st,
                                      logic [SAMPLE_W-1:0] smp, logic lst);
    fifo_result_t r;
    r.status = st;
    r.sample = smp;
    r.last   = lst;
    r.fill   = shadow_held[FILL_W-1:0];
    predicted_results.push_back(r);
  endfunction

  // Advance the shadow FIFO by one accepted item and queue its results.
  task automatic predict_response(input logic op, input logic [SAMPLE_W-1:0] sample,
                                  input logic voice, input logic [COUNT_W-1:0] count);
    asf_pkg::status_t    st;
    logic [SAMPLE_W-1:0] v;
    int unsigned         k;
    begin
      if (op == asf_pkg::OP_WRITE) begin
        if (!voice) begin
          push_result(asf_pkg::ST_REJECTED, '0, 1'b1);
        end else begin
          st = asf_pkg::ST_WRITTEN;
          // A full store loses its oldest sample to make room.
          if (shadow_held >= DEPTH) begin
            shadow_oldest = (shadow_oldest + 1) % DEPTH;
            shadow_held   = DEPTH - 1;
            st            = asf_pkg::ST_DROPPED;
          end
          shadow_store[ADDR_W'((shadow_oldest + shadow_held) % DEPTH)] = sample;
          shadow_held++;
          push_result(st, '0, 1'b1);
        end
      end else if (count == 0 || count > MAX_READ || shadow_held < count) begin
        // Bad counts and short stores both leave the FIFO untouched.
        push_result(asf_pkg::ST_SHORT, '0, 1'b1);
      end else begin
        for (k = 0; k < count; k++) begin
          v             = shadow_store[ADDR_W'(shadow_oldest)];
          shadow_oldest = (shadow_oldest + 1) % DEPTH;
          shadow_held--;
          push_result(asf_pkg::ST_DATA, v, k + 1 == count);
        end
      end
    end
  endtask

  // Drive one item, with random idle cycles first, and wait for acceptance.
  // Start is left high, so a following item can go in on the next cycle.
  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] sample,
                           input logic voice, input logic fend,
                           input logic [COUNT_W-1:0] count);
    begin
      @(negedge clk);
      while ($urandom_range(0, 99) < send_gap_pct) begin
        // Junk on the fields while idle must be ignored.
        start         = 1'b0;
        in_op         = 1'($urandom_range(0, 1));
        in_sample_in  = SAMPLE_W'($urandom);
        in_is_voice   = 1'($urandom_range(0, 1));
        in_frame_end  = 1'($urandom_range(0, 1));
        in_read_count = COUNT_W'($urandom);
        @(negedge clk);
      end
      start         = 1'b1;
      in_op         = op;
      in_sample_in  = sample;
      in_is_voice   = voice;
      in_frame_end  = fend;
      in_read_count = count;
      @(posedge clk);
      while (busy) @(posedge clk);
      predict_response(op, sample, voice, count);
    end
  endtask

  task automatic write_sample(input logic [SAMPLE_W-1:0] sample, input logic voice,
                              input logic fend);
    send_item(asf_pkg::OP_WRITE, sample, voice, fend, COUNT_W'($urandom));
  endtask

  task automatic read_block(input logic [COUNT_W-1:0] count);
    send_item(asf_pkg::OP_READ, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), count);
  endtask

  // One random item: mostly voice writes and modest reads, plus bad counts.
  task automatic random_item;
    int pick;
    begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        write_sample(SAMPLE_W'($urandom), $urandom_range(0, 9) != 0,
                     1'($urandom_range(0, 1)));
      end else if (pick < 60) begin
        read_block($urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(MAX_READ + 1, 127)));
      end else if (pick < 70) begin
        read_block(COUNT_W'($urandom_range(1, MAX_READ)));
      end else begin
        read_block(COUNT_W'($urandom_range(1, 10)));
      end
    end
  endtask

  // Extremes of the fields, rejects, short reads and bad counts.
  task automatic test_directed;
    begin
      send_gap_pct = 0;
      read_block(7'd1);
      read_block(7'd0);
      read_block(7'd127);
      read_block(7'd65);
      write_sample(16'h5555, 1'b0, 1'b1);
      write_sample(16'h8000, 1'b1, 1'b1);
      write_sample(16'h7FFF, 1'b1, 1'b0);
      write_sample(16'h0000, 1'b1, 1'b1);
      write_sample(16'hFFFF, 1'b1, 1'b0);
      write_sample(16'h0001, 1'b1, 1'b1);
      read_block(7'd3);
      read_block(7'd0);
      read_block(7'd65);
      read_block(7'd5);
      read_block(7'd2);
      read_block(7'd1);
      write_sample(16'hAAAA, 1'b0, 1'b0);
      write_sample(16'h1234, 1'b1, 1'b1);
      read_block(7'd1);
      read_block(7'd1);
    end
  endtask

  // Fill past the depth so the oldest samples drop, work near full, then drain.
  task automatic test_store_full;
    int n;
    begin
      send_gap_pct = 0;
      for (n = 0; n < DEPTH + 8; n++) begin
        write_sample(SAMPLE_W'($urandom), 1'b1, n % 4 == 3);
      end
      write_sample(16'h7FFF, 1'b0, 1'b1);
      read_block(7'd65);
      read_block(7'd64);
      // Small reads keep the store close to full, so refills hit the drop path.
      for (n = 0; n < 120; n++) begin
        if (n % 6 == 5) begin
          read_block(COUNT_W'($urandom_range(1, 3)));
        end else begin
          write_sample(SAMPLE_W'($urandom), $urandom_range(0, 7) != 0,
                       1'($urandom_range(0, 1)));
        end
      end
      send_gap_pct = 26;
      while (shadow_held >= MAX_READ) read_block(COUNT_W'(MAX_READ));
      if (shadow_held > 0) read_block(shadow_held[COUNT_W-1:0]);
    end
  endtask

  // Random traffic at a given sender idle rate.
  task automatic test_random_traffic(input int gap_pct, input int items);
    int n;
    begin
      send_gap_pct = gap_pct;
      for (n = 0; n < items; n++) random_item();
    end
  endtask

  // Compare each strobed result with the oldest prediction.
  task automatic report_mismatch(input string what, input fifo_result_t want);
    begin
      if (mismatch_count < 10) begin
        $display("mismatch (%s) at %0t: expected status %0d sample %0d last %0b fill %0d,",
                 what, $realtime, want.status, $signed(want.sample), want.last, want.fill);
        $display("  got status %0d sample %0d last %0b fill %0d",
                 out_status, out_sample_out, out_last, out_fill_level);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected result", '0);
      end else begin
        due_result = predicted_results.pop_front();
        if (out_status !== due_result.status || out_sample_out !== due_result.sample ||
            out_last !== due_result.last || out_fill_level !== due_result.fill) begin
          report_mismatch("wrong field", due_result);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Reset, the tests in turn, then wait for the last results.
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = asf_pkg::OP_WRITE;
    in_sample_in   = '0;
    in_is_voice    = 1'b0;
    in_frame_end   = 1'b0;
    in_read_count  = '0;
    shadow_oldest  = 0;
    shadow_held    = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_gap_pct   = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_store_full();
    test_random_traffic(0, 70);
    test_random_traffic(68, 70);
    test_random_traffic(26, 70);

    @(negedge clk);
    start = 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/asf_pkg.sv
hw/rtl/asf_ram.sv
hw/rtl/asf_ctrl.sv
hw/rtl/asf_dp.sv
hw/rtl/audio_sample_fifo_drop_oldest.sv
hw/rtl/asf_chk.sv
dv/testbench.sv
